@@ rtl/pngx_pkg.sv @@
// Shared types and constants for the PNG eXIf chunk extractor.
// Used by pngx_parser, pngx_out_stage and png_exif_chunk_extractor.
// No dependencies.
`default_nettype none

package pngx_pkg;

  // Width of the internal file length and byte position
  localparam int LENGTH_BITS = 32;
  localparam int LEN_IN_W    = 32;
  localparam int CHUNK_W     = 32;
  // Header end + chunk length + CRC, formed without wrap
  localparam int SUM_W       = ((LENGTH_BITS > CHUNK_W) ? LENGTH_BITS : CHUNK_W) + 2;
  // Body plus CRC countdown
  localparam int REM_W       = CHUNK_W + 1;
  localparam int PREFIX_LEN  = 6;
  localparam int BEAT_W      = $clog2(PREFIX_LEN);

  localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] TAG_BYTES [4] = '{8'h65, 8'h58, 8'h49, 8'h66};
  localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{8'h45, 8'h78, 8'h69,
                                                       8'h66, 8'h00, 8'h00};

  // What one accepted byte hands to the output stage
  typedef enum logic [1:0] {
    RES_BYTE,
    RES_PREFIX,
    RES_MARK
  } res_kind_t;

  typedef struct packed {
    logic       valid;
    res_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  // Clamp the incoming length to LENGTH_BITS bits
  function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LEN_IN_W-1:0] x);
    logic [LENGTH_BITS-1:0] r;
    r = LENGTH_BITS'(x);
    if (LENGTH_BITS < LEN_IN_W && (x >> LENGTH_BITS) != '0) begin
      r = '1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pngx_parser.sv @@
// Chunk walker: signature check, header decode, skip and body tracking.
// Updates its state on each input transfer and hands a result descriptor
// to the output stage. Depends on pngx_pkg.
`default_nettype none

module pngx_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 first_byte,
  input  wire logic [31:0]          file_length,
  output pngx_pkg::res_t            res
);
  import pngx_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_HDR,
    PH_SKIP,
    PH_EMIT,
    PH_IDLE,
    PH_DONE
  } phase_t;

  phase_t                  phase_r, phase_nxt, cur_phase;
  logic [LENGTH_BITS-1:0]  pos_r, pos_nxt, cur_pos;
  logic [2:0]              hi_r, hi_nxt, cur_hi;
  logic [CHUNK_W-1:0]      chunk_r, chunk_nxt, cur_chunk, chunk_base;
  logic                    type_r, type_nxt, cur_type, type_base;
  logic [REM_W-1:0]        rem_r, rem_nxt, cur_rem, rem_dec;
  logic                    sig_r, sig_nxt, cur_sig;
  logic                    over_r, over_nxt, cur_over;
  logic [LENGTH_BITS-1:0]  len;
  logic                    hdr_short, overrun;

  // Next state for one byte
  always_comb begin
    // first_byte restarts everything before the byte is looked at
    cur_phase = phase_r;
    cur_pos   = pos_r;
    cur_hi    = hi_r;
    cur_chunk = chunk_r;
    cur_type  = type_r;
    cur_rem   = rem_r;
    cur_sig   = sig_r;
    cur_over  = over_r;
    if (first_byte) begin
      cur_phase = PH_SIG;
      cur_pos   = '0;
      cur_hi    = '0;
      cur_chunk = '0;
      cur_type  = 1'b1;
      cur_rem   = '0;
      cur_sig   = 1'b1;
      cur_over  = 1'b0;
    end

    phase_nxt = cur_phase;
    pos_nxt   = cur_pos;
    hi_nxt    = cur_hi;
    chunk_nxt = cur_chunk;
    type_nxt  = cur_type;
    rem_nxt   = cur_rem;
    sig_nxt   = cur_sig;
    over_nxt  = cur_over;
    res       = '0;

    len        = sat_len(file_length);
    hdr_short  = ({1'b0, cur_pos} + (LENGTH_BITS+1)'(8)) > {1'b0, len};
    overrun    = (SUM_W'(cur_pos) + SUM_W'(cur_chunk) + SUM_W'(5)) > SUM_W'(len);
    rem_dec    = cur_rem - REM_W'(cur_rem != '0);
    chunk_base = (cur_hi == '0) ? '0 : cur_chunk;
    type_base  = (cur_hi == '0) ? 1'b1 : cur_type;

    // Bytes past the end of the file are ignored
    if (cur_pos < len) begin
      pos_nxt = cur_pos + LENGTH_BITS'(1);
      unique case (cur_phase)
        PH_SIG: begin
          sig_nxt = cur_sig & (byte_value == SIG_BYTES[cur_pos[2:0]]);
          if (cur_pos >= LENGTH_BITS'(7)) begin
            phase_nxt = sig_nxt ? PH_HDR : PH_IDLE;
            hi_nxt    = '0;
          end
        end
        PH_HDR: begin
          if (cur_hi == '0 && hdr_short) begin
            phase_nxt = PH_IDLE;
          end else begin
            // length bytes first, then the type bytes
            chunk_nxt = chunk_base;
            type_nxt  = type_base;
            if (!cur_hi[2]) begin
              chunk_nxt = {chunk_base[CHUNK_W-9:0], byte_value};
            end else begin
              type_nxt = type_base & (byte_value == TAG_BYTES[cur_hi[1:0]]);
            end
            if (cur_hi == 3'd7) begin
              hi_nxt = '0;
              if (overrun) begin
                phase_nxt = PH_IDLE;
              end else if (type_nxt) begin
                res.valid = 1'b1;
                res.kind  = RES_PREFIX;
                res.last  = (cur_chunk == '0);
                if (cur_chunk == '0) begin
                  phase_nxt = PH_DONE;
                  over_nxt  = 1'b1;
                end else begin
                  rem_nxt   = REM_W'(cur_chunk);
                  phase_nxt = PH_EMIT;
                end
              end else begin
                rem_nxt   = REM_W'(cur_chunk) + REM_W'(4);
                phase_nxt = PH_SKIP;
              end
            end else begin
              hi_nxt = cur_hi + 3'd1;
            end
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_HDR;
            hi_nxt    = '0;
          end
        end
        PH_EMIT: begin
          rem_nxt   = rem_dec;
          res.valid = 1'b1;
          res.kind  = RES_BYTE;
          res.data  = byte_value;
          res.last  = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_DONE;
            over_nxt  = 1'b1;
          end
        end
        default: ;
      endcase

      // Final byte with no find gives the not-found marker
      if (pos_nxt == len && !over_nxt && phase_nxt != PH_EMIT && phase_nxt != PH_DONE) begin
        res.valid = 1'b1;
        res.kind  = RES_MARK;
        res.data  = '0;
        res.last  = 1'b1;
        over_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      pos_r   <= '0;
      hi_r    <= '0;
      chunk_r <= '0;
      type_r  <= 1'b1;
      rem_r   <= '0;
      sig_r   <= 1'b1;
      over_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hi_r    <= hi_nxt;
      chunk_r <= chunk_nxt;
      type_r  <= type_nxt;
      rem_r   <= rem_nxt;
      sig_r   <= sig_nxt;
      over_r  <= over_nxt;
    end
  end

  // A body being emitted always has bytes left to go
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EMIT |-> rem_r != '0)
    else $error("emit phase with nothing remaining");

  // Once the search is over the walker only idles or has finished
  assert property (@(posedge clk) disable iff (!rst_n)
    over_r |-> (phase_r == PH_DONE || phase_r == PH_IDLE))
    else $error("search over but walker still active");

  // Header byte counter only moves inside a header; a file that ends
  // part way through a header leaves it standing in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    hi_r != '0 |-> (phase_r == PH_HDR || phase_r == PH_IDLE))
    else $error("header index set outside header phase");

endmodule

`default_nettype wire

@@ rtl/pngx_out_stage.sv @@
// Result register: holds one descriptor and plays it out, stepping through
// the six Exif prefix bytes when needed. Depends on pngx_pkg.
`default_nettype none

module pngx_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire pngx_pkg::res_t res,
  output logic                slot_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_out,
  output logic                out_found
);
  import pngx_pkg::*;

  logic              valid_r;
  res_kind_t         kind_r;
  logic [7:0]        data_r;
  logic              last_r;
  logic [BEAT_W-1:0] beat_r;
  logic              final_beat;
  logic              take;

  // Drive the result channel from the held descriptor
  always_comb begin
    final_beat   = (kind_r != RES_PREFIX) || (beat_r == BEAT_W'(PREFIX_LEN - 1));
    take         = valid_r && out_ready;
    slot_free    = !valid_r || (take && final_beat);
    out_valid    = valid_r;
    out_byte     = (kind_r == RES_PREFIX) ? PREFIX_BYTES[beat_r] : data_r;
    out_last_out = last_r && final_beat;
    out_found    = (kind_r != RES_MARK);
  end

  // Descriptor and prefix beat counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
    end else if (take) begin
      if (final_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      data_r <= res.data;
      last_r <= res.last;
    end
  end

  // A new descriptor never lands on one still being played out
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("descriptor loaded over a pending one");

  // Only prefix descriptors step the beat counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != RES_PREFIX) |-> beat_r == '0)
    else $error("beat counter moved on a single-byte result");

  // Beat counter stays within the prefix
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> beat_r <= BEAT_W'(PREFIX_LEN - 1))
    else $error("prefix beat out of range");

endmodule

`default_nettype wire

@@ rtl/png_exif_chunk_extractor.sv @@
// Top level of the PNG eXIf chunk extractor: chunk walker plus result
// register. Depends on pngx_pkg, pngx_parser and pngx_out_stage.
//
// Use: feed a PNG file one byte per transfer on the in_ channel, with
// in_first_byte high on byte 0 and the total length on every transfer.
// The out_ channel returns the Exif segment: 'Exif',0,0 then the body of
// the first eXIf chunk, out_last_out on its final byte, out_found high.
// When the search ends without a find, the last file byte gives a single
// transfer with out_found low and out_last_out high.
// A result is registered: it shows the cycle after the byte causing it.
// Throughput: one byte per cycle while the receiver keeps up. The six prefix
// bytes leave one a cycle from the result register, so the byte after the
// last eXIf type byte waits for them; every other byte flows at one per cycle.
// Stalls: in_ready drops while the result register holds a transfer the
// receiver has not taken, so a stalled receiver holds off the input.
// Reset (synchronous, rst_n low) returns the walker to the signature
// check and empties the result register.
`default_nettype none

module png_exif_chunk_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_first_byte,
  input  wire logic [31:0] in_file_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_out,
  output logic             out_found
);
  import pngx_pkg::*;

  logic accept;
  logic slot_free;
  res_t res;

  assign in_ready = slot_free;
  assign accept   = in_valid && slot_free;

  pngx_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_value  (in_byte_value),
    .first_byte  (in_first_byte),
    .file_length (in_file_length),
    .res         (res)
  );

  pngx_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept && res.valid),
    .res          (res),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_out (out_last_out),
    .out_found    (out_found)
  );

endmodule

`default_nettype wire
